/* hdl/zero_run_gamma_encoder_macros.svh */
// assertion macros for the zero-run gamma encoder
// used by the top level only, no other dependencies
`ifndef ZERO_RUN_GAMMA_ENCODER_MACROS_SVH
`define ZERO_RUN_GAMMA_ENCODER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define ZRG_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("zrg assertion failed");

// next-cycle implication, checked while out of reset
`define ZRG_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("zrg assertion failed");

`endif

/* hdl/zrg_pkg.sv */
// shared types, constants and helpers for the zero-run gamma encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package zrg_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int MAG_W       = 31;
    localparam int CODE_W      = 63;
    localparam int LEN_W       = 6;
    localparam int LOG_W       = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SAMPLE_W-1:0] RUN_ONE = 32'd1;
    localparam logic [SAMPLE_W-1:0] RUN_MAX = 32'hFFFF_FFFF;
    localparam logic [MAG_W-1:0]    MAG_MAX = 31'h7FFF_FFFF;

    // one queue entry: either a lone trailing run code or a full run/sign/magnitude group
    typedef struct packed {
        logic                single;
        logic [SAMPLE_W-1:0] run;
        logic                neg;
        logic [MAG_W-1:0]    mag;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        W_RUN  = 3'b001,
        W_SIGN = 3'b010,
        W_MAG  = 3'b100
    } word_t;

    function automatic logic [LOG_W-1:0] floor_log2(input logic [SAMPLE_W-1:0] n);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            if (n[i])
            begin
                r = LOG_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/zero_run_gamma_encoder.sv */
// zero-run gamma encoder: signed samples in, variable-length code words out
// sample channel: sample_valid / sample_stall carry sample and is_final
// code channel: code_valid / code_stall carry code_bits, code_length, run_end
// a zero sample that is not final only extends the run and produces nothing
// a nonzero sample produces three words: run gamma, sign bit, magnitude gamma
// a zero sample marked final produces one word, the gamma code of the run
// words leave one per cycle while code_stall is low, so for nonzero samples the
// output register is the limit; zero samples are taken one per cycle while the
// queue is not full; the first word is written to the queue at the transfer edge
// and loaded into the output reg once earlier words and code_stall allow
// a queue of QUEUE_DEPTH groups sits between sample side and word side
// if code_stall is held, the queue fills and sample_stall rises once it is full
// reset empties the queue, drops code_valid and sets the run count to one
// depends on zrg_pkg, zrg_front, zrg_queue, zrg_back and the macros header
`timescale 1ns / 1ps
`default_nettype none

`include "zero_run_gamma_encoder_macros.svh"

module zero_run_gamma_encoder
#(
    parameter int QUEUE_DEPTH = zrg_pkg::QUEUE_DEPTH
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         sample_valid,
    output logic                              sample_stall,
    input  wire logic [zrg_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                         is_final,
    output logic                              code_valid,
    input  wire logic                         code_stall,
    output logic [zrg_pkg::CODE_W-1:0]        code_bits,
    output logic [zrg_pkg::LEN_W-1:0]         code_length,
    output logic                              run_end
);

    zrg_pkg::q_stat_t q_stat;
    zrg_pkg::entry_t  push_entry;
    zrg_pkg::entry_t  head;
    logic             push;
    logic             pop;

    zrg_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample       (sample),
        .is_final     (is_final),
        .q_stat       (q_stat),
        .sample_stall (sample_stall),
        .push         (push),
        .push_entry   (push_entry)
    );

    zrg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    zrg_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .code_valid  (code_valid),
        .code_stall  (code_stall),
        .code_bits   (code_bits),
        .code_length (code_length),
        .run_end     (run_end)
    );

    // every word length is odd: gamma codes and the one-bit sign word
    `ZRG_ASSERT_IMPLIES(a_len_odd, clk, rst_n, code_valid, code_length[0])
    // code words never reach past 32 value bits
    `ZRG_ASSERT_IMPLIES(a_bits_narrow, clk, rst_n, code_valid, code_bits[62:32] == 31'd0)
    // a multi-bit word is a gamma code: its top set bit sits at half the length
    `ZRG_ASSERT_IMPLIES(a_gamma_form, clk, rst_n, code_valid && code_length != 6'd1,
                        (code_bits >> code_length[5:1]) == 63'd1)
    // a transfer that does not close a group is followed by another word right away
    `ZRG_ASSERT_NEXT(a_group_cont, clk, rst_n, code_valid && !code_stall && !run_end, code_valid)

endmodule

`default_nettype wire

/* hdl/zrg_front.sv */
// front end: takes samples, tracks the zero run and queues code groups
// depends on zrg_pkg
`timescale 1ns / 1ps
`default_nettype none

module zrg_front
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         sample_valid,
    input  wire logic [zrg_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                         is_final,
    input  wire zrg_pkg::q_stat_t             q_stat,
    output logic                              sample_stall,
    output logic                              push,
    output zrg_pkg::entry_t                   push_entry
);

    logic [zrg_pkg::SAMPLE_W-1:0] run_reg;
    logic [zrg_pkg::SAMPLE_W-1:0] run_next;
    logic [zrg_pkg::SAMPLE_W-1:0] run_inc;
    logic [zrg_pkg::SAMPLE_W-1:0] mag_full;
    logic                         accept;
    logic                         is_zero;
    logic                         neg;

    assign sample_stall = q_stat.full;
    assign accept       = sample_valid && !q_stat.full;
    assign is_zero      = (sample == '0);
    assign neg          = sample[zrg_pkg::SAMPLE_W-1];
    assign mag_full     = neg ? (~sample + 1'b1) : sample;
    assign run_inc      = (run_reg == zrg_pkg::RUN_MAX) ? run_reg : run_reg + 1'b1;

    always_comb
    begin
        push_entry.single = is_zero;
        push_entry.run    = is_zero ? run_inc : run_reg;
        push_entry.neg    = neg;
        // most negative sample clamps to the largest magnitude
        push_entry.mag    = mag_full[zrg_pkg::SAMPLE_W-1] ? zrg_pkg::MAG_MAX
                                                          : mag_full[zrg_pkg::MAG_W-1:0];
        push     = accept && (!is_zero || is_final);
        run_next = run_reg;
        if (accept)
        begin
            if (is_zero && !is_final)
            begin
                run_next = run_inc;
            end
            else
            begin
                run_next = zrg_pkg::RUN_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= zrg_pkg::RUN_ONE;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/zrg_queue.sv */
// small register queue between the front and back ends
// depends on zrg_pkg
`timescale 1ns / 1ps
`default_nettype none

module zrg_queue
#(
    parameter int DEPTH = zrg_pkg::QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire zrg_pkg::entry_t  push_entry,
    input  wire logic             pop,
    output zrg_pkg::entry_t       head,
    output zrg_pkg::q_stat_t      q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    zrg_pkg::entry_t  store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head         = store[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/zrg_back.sv */
// back end: turns queued groups into output-reg code words, one per cycle when not stalled
// depends on zrg_pkg
`timescale 1ns / 1ps
`default_nettype none

module zrg_back
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire zrg_pkg::entry_t            head,
    input  wire zrg_pkg::q_stat_t           q_stat,
    output logic                            pop,
    output logic                            code_valid,
    input  wire logic                       code_stall,
    output logic [zrg_pkg::CODE_W-1:0]      code_bits,
    output logic [zrg_pkg::LEN_W-1:0]       code_length,
    output logic                            run_end
);

    zrg_pkg::word_t                 word_reg;
    zrg_pkg::word_t                 word_next;
    logic                           valid_reg;
    logic                           valid_next;
    logic [zrg_pkg::CODE_W-1:0]     bits_reg;
    logic [zrg_pkg::CODE_W-1:0]     bits_next;
    logic [zrg_pkg::LEN_W-1:0]      len_reg;
    logic [zrg_pkg::LEN_W-1:0]      len_next;
    logic                           end_reg;
    logic                           end_next;
    logic [zrg_pkg::SAMPLE_W-1:0]   gamma_val;
    logic [zrg_pkg::LOG_W-1:0]      gamma_log;
    logic                           load;
    logic                           last_word;

    assign load      = !q_stat.empty && (!valid_reg || !code_stall);
    assign last_word = head.single || (word_reg == zrg_pkg::W_MAG);
    assign pop       = load && last_word;
    assign gamma_val = (word_reg == zrg_pkg::W_MAG) ? {1'b0, head.mag} : head.run;
    assign gamma_log = zrg_pkg::floor_log2(gamma_val);

    always_comb
    begin
        bits_next  = bits_reg;
        len_next   = len_reg;
        end_next   = end_reg;
        word_next  = word_reg;
        valid_next = valid_reg && code_stall;
        if (load)
        begin
            valid_next = 1'b1;
            end_next   = last_word;
            case (word_reg)
                zrg_pkg::W_SIGN:
                begin
                    bits_next = zrg_pkg::CODE_W'(!head.neg);
                    len_next  = zrg_pkg::LEN_W'(1);
                end
                zrg_pkg::W_RUN, zrg_pkg::W_MAG:
                begin
                    bits_next = zrg_pkg::CODE_W'(gamma_val);
                    len_next  = {gamma_log, 1'b1};
                end
                default:
                begin
                    bits_next = '0;
                    len_next  = '0;
                end
            endcase
            if (last_word)
            begin
                word_next = zrg_pkg::W_RUN;
            end
            else if (word_reg == zrg_pkg::W_RUN)
            begin
                word_next = zrg_pkg::W_SIGN;
            end
            else
            begin
                word_next = zrg_pkg::W_MAG;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        len_reg  <= len_next;
        end_reg  <= end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= zrg_pkg::W_RUN;
            valid_reg <= 1'b0;
        end
        else
        begin
            word_reg  <= word_next;
            valid_reg <= valid_next;
        end
    end

    assign code_valid  = valid_reg;
    assign code_bits   = bits_reg;
    assign code_length = len_reg;
    assign run_end     = end_reg;

endmodule

`default_nettype wire
